@@ sv/rov_pkg.sv @@
// ----------------------------------------------------------------------------
// rov_pkg
// Shared constants, types and codes of the read overlap verifier.
// ----------------------------------------------------------------------------
package rov_pkg;

   localparam int READ_CAPACITY = 256;
   localparam int ADDR_W        = $clog2(READ_CAPACITY);
   localparam int LEN_W         = 9;
   localparam int OFF_W         = 8;
   localparam int BASE_W        = 8;
   localparam int CNT_W         = 9;
   localparam int FUNC_W        = 2;
   localparam int OVL_CFG_W     = 9;
   localparam int SIM_W         = 11;
   localparam int SIM_FRAC_W    = 10;
   localparam int SIM_ONE       = 1 << SIM_FRAC_W;
   localparam int PROD_W        = SIM_W + CNT_W;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 11;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = QPTR_W + 1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_ONE = 2'd0,
      FUNC_LOAD_TWO = 2'd1,
      FUNC_EVAL     = 2'd2,
      FUNC_NONE     = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_OVERLAP    = 4'd0,
      CSR_MIN_SIMILARITY = 4'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_LOAD_ONE,
      OP_LOAD_TWO,
      OP_EVAL
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_DECIDE
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [BASE_W-1:0]   base;
      logic                invalid;
      logic [ADDR_W-1:0]   start_one;
      logic [ADDR_W-1:0]   start_two;
      logic [LEN_W-1:0]    overlap;
   } queue_entry_type;

   typedef struct packed {
      logic [OVL_CFG_W-1:0] min_overlap;
      logic [SIM_W-1:0]     min_similarity;
   } cfg_type;

endpackage

@@ sv/rov_ram.sv @@
// ----------------------------------------------------------------------------
// rov_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rov_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rov_front.sv @@
// ----------------------------------------------------------------------------
// rov_front
// Accepts request transactions, clamps lengths, checks offsets and works out
// the overlap window, then pushes one queue entry per useful transaction.
// ----------------------------------------------------------------------------
module rov_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rov_pkg::FUNC_W-1:0]   req_func,
   input  logic [rov_pkg::OFF_W-1:0]    req_position,
   input  logic [rov_pkg::BASE_W-1:0]   req_base,
   input  logic [rov_pkg::LEN_W-1:0]    req_length_one,
   input  logic [rov_pkg::OFF_W-1:0]    req_offset_one,
   input  logic [rov_pkg::LEN_W-1:0]    req_length_two,
   input  logic [rov_pkg::OFF_W-1:0]    req_offset_two,
   input  logic                         queue_full,
   output logic                         push,
   output rov_pkg::queue_entry_type     push_entry
);
   import rov_pkg::*;

   logic [LEN_W-1:0] len_one;
   logic [LEN_W-1:0] len_two;
   logic [LEN_W-1:0] off_one;
   logic [LEN_W-1:0] off_two;
   logic [LEN_W-1:0] rest_one;
   logic [LEN_W-1:0] rest_two;
   logic [LEN_W-1:0] rgt;
   logic [OFF_W-1:0] lft;
   logic             in_store;
   logic             keep;

   always_comb begin
      len_one  = (req_length_one > LEN_W'(READ_CAPACITY)) ? LEN_W'(READ_CAPACITY)
                                                          : req_length_one;
      len_two  = (req_length_two > LEN_W'(READ_CAPACITY)) ? LEN_W'(READ_CAPACITY)
                                                          : req_length_two;
      off_one  = LEN_W'(req_offset_one);
      off_two  = LEN_W'(req_offset_two);
      rest_one = len_one - off_one;
      rest_two = len_two - off_two;
      rgt      = (rest_one <= rest_two) ? rest_one : rest_two;
      lft      = (req_offset_one <= req_offset_two) ? req_offset_one : req_offset_two;
      in_store = (LEN_W'(req_position) < LEN_W'(READ_CAPACITY));

      push_entry.addr      = ADDR_W'(req_position);
      push_entry.base      = req_base;
      push_entry.invalid   = (off_one >= len_one) || (off_two >= len_two);
      push_entry.start_one = ADDR_W'(req_offset_one - lft);
      push_entry.start_two = ADDR_W'(req_offset_two - lft);
      push_entry.overlap   = LEN_W'(lft) + rgt;

      unique case (func_type'(req_func))
         FUNC_LOAD_ONE: begin
            push_entry.op = OP_LOAD_ONE;
            keep          = in_store;
         end
         FUNC_LOAD_TWO: begin
            push_entry.op = OP_LOAD_TWO;
            keep          = in_store;
         end
         FUNC_EVAL: begin
            push_entry.op = OP_EVAL;
            keep          = 1'b1;
         end
         default: begin
            push_entry.op = OP_EVAL;
            keep          = 1'b0;
         end
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && keep;

endmodule

@@ sv/rov_queue.sv @@
// ----------------------------------------------------------------------------
// rov_queue
// Short register FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module rov_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rov_pkg::queue_entry_type   push_entry,
   output logic                       full,
   input  logic                       pop,
   output logic                       head_valid,
   output rov_pkg::queue_entry_type   head_entry
);
   import rov_pkg::*;

   queue_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

endmodule

@@ sv/rov_back.sv @@
// ----------------------------------------------------------------------------
// rov_back
// Executes queued transactions: writes bases into the read stores, walks the
// overlap window of an evaluation and produces the registered response.
// ----------------------------------------------------------------------------
module rov_back (
   input  logic                         clock,
   input  logic                         reset,
   input  rov_pkg::cfg_type             cfg,
   input  logic                         head_valid,
   input  rov_pkg::queue_entry_type     head_entry,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rov_pkg::CNT_W-1:0]    rsp_overlap_length,
   output logic [rov_pkg::CNT_W-1:0]    rsp_mismatch_count,
   output logic                         rsp_accepted,
   output logic                         rsp_invalid
);
   import rov_pkg::*;

   back_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  start_one_ff, start_two_ff;
   logic [LEN_W-1:0]   overlap_ff;
   logic               invalid_ff;
   logic [CNT_W-1:0]   mm_ff, mm_in;
   logic               rd_vld_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_overlap_ff, rsp_mm_ff;
   logic               rsp_accepted_ff, rsp_invalid_ff;

   logic               out_free;
   logic               take_eval;
   logic               decide_fire;
   logic               last_idx;
   logic               wr_one, wr_two, rd_en;
   logic [ADDR_W-1:0]  rd_addr_one, rd_addr_two;
   logic [BASE_W-1:0]  base_one, base_two;
   logic [SIM_W-1:0]   sim_clamped;
   logic [SIM_W-1:0]   slack;
   logic [PROD_W-1:0]  allowed;
   logic [PROD_W-1:0]  scaled_mm;
   logic               pass;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign last_idx = (LEN_W'(idx_ff) == overlap_ff - LEN_W'(1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && head_entry.op == OP_EVAL) begin
               state_in = head_entry.invalid ? ST_DECIDE : ST_WALK;
            end
         end
         ST_WALK: begin
            if (last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      pop         = 1'b0;
      wr_one      = 1'b0;
      wr_two      = 1'b0;
      rd_en       = 1'b0;
      take_eval   = 1'b0;
      decide_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop       = head_valid;
            wr_one    = head_valid && head_entry.op == OP_LOAD_ONE;
            wr_two    = head_valid && head_entry.op == OP_LOAD_TWO;
            take_eval = head_valid && head_entry.op == OP_EVAL;
         end
         ST_WALK: begin
            rd_en = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_DECIDE: begin
            decide_fire = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rd_addr_one = start_one_ff + idx_ff;
   assign rd_addr_two = start_two_ff + idx_ff;

   rov_ram #(
      .WIDTH(BASE_W),
      .DEPTH(READ_CAPACITY)
   ) u_store_one (
      .clock  (clock),
      .wr_en  (wr_one),
      .wr_addr(head_entry.addr),
      .wr_data(head_entry.base),
      .rd_en  (rd_en),
      .rd_addr(rd_addr_one),
      .rd_data(base_one)
   );

   rov_ram #(
      .WIDTH(BASE_W),
      .DEPTH(READ_CAPACITY)
   ) u_store_two (
      .clock  (clock),
      .wr_en  (wr_two),
      .wr_addr(head_entry.addr),
      .wr_data(head_entry.base),
      .rd_en  (rd_en),
      .rd_addr(rd_addr_two),
      .rd_data(base_two)
   );

   always_comb begin
      idx_in = idx_ff;
      mm_in  = mm_ff;
      if (take_eval) begin
         idx_in = '0;
         mm_in  = '0;
      end else begin
         if (state_ff == ST_WALK) begin
            idx_in = idx_ff + ADDR_W'(1);
         end
         if (rd_vld_ff && base_one != base_two) begin
            mm_in = mm_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      sim_clamped = (cfg.min_similarity > SIM_W'(SIM_ONE)) ? SIM_W'(SIM_ONE)
                                                          : cfg.min_similarity;
      slack       = SIM_W'(SIM_ONE) - sim_clamped;
      allowed     = PROD_W'(slack) * PROD_W'(overlap_ff);
      scaled_mm   = PROD_W'(mm_ff) << SIM_FRAC_W;
      pass        = (overlap_ff >= LEN_W'(cfg.min_overlap)) && (scaled_mm <= allowed);
   end

   always_comb begin
      if (decide_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      mm_ff  <= mm_in;
      if (take_eval) begin
         start_one_ff <= head_entry.start_one;
         start_two_ff <= head_entry.start_two;
         overlap_ff   <= head_entry.overlap;
         invalid_ff   <= head_entry.invalid;
      end
      if (decide_fire) begin
         rsp_invalid_ff <= invalid_ff;
         if (invalid_ff) begin
            rsp_overlap_ff  <= '0;
            rsp_mm_ff       <= '0;
            rsp_accepted_ff <= 1'b0;
         end else begin
            rsp_overlap_ff  <= overlap_ff;
            rsp_mm_ff       <= mm_ff;
            rsp_accepted_ff <= pass;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_overlap_length = rsp_overlap_ff;
   assign rsp_mismatch_count = rsp_mm_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_invalid        = rsp_invalid_ff;

endmodule

@@ sv/read_overlap_verifier.sv @@
// ----------------------------------------------------------------------------
// read_overlap_verifier
// Ungapped overlap check of two stored sequence reads.
//
// The request channel carries load transactions (func 0 or 1 write one base
// of read one or read two at position) and evaluate transactions (func 2,
// with both lengths and seed offsets). Func 3 is dropped. Every evaluate gives
// one response: overlap length, mismatch count, accepted and invalid. The CSR
// channel writes min_overlap (index 0) and min_similarity (index 1); it is
// always ready.
// A front stage classifies requests into a four-entry queue, so the request
// side takes one transaction per cycle until the queue fills. The back stage
// executes loads at one per cycle while it is idle; an evaluate occupies it
// through the walk, drain and decide states, one stored base pair read per
// cycle from the two read RAMs during the walk, and its response registers
// are loaded when decide fires. Invalid evaluations go straight to decide.
// Reset clears the queue, the sequencer and the response valid, and sets the
// thresholds to 5 and 922; store contents stay undefined until written.
// While rsp_stall is high the response holds; the back stage keeps executing
// loads and walking the next evaluate, and the queue fills before req_stall.
// ----------------------------------------------------------------------------
module read_overlap_verifier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rov_pkg::FUNC_W-1:0]        req_func,
   input  logic [rov_pkg::OFF_W-1:0]         req_position,
   input  logic [rov_pkg::BASE_W-1:0]        req_base,
   input  logic [rov_pkg::LEN_W-1:0]         req_length_one,
   input  logic [rov_pkg::OFF_W-1:0]         req_offset_one,
   input  logic [rov_pkg::LEN_W-1:0]         req_length_two,
   input  logic [rov_pkg::OFF_W-1:0]         req_offset_two,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rov_pkg::CNT_W-1:0]         rsp_overlap_length,
   output logic [rov_pkg::CNT_W-1:0]         rsp_mismatch_count,
   output logic                              rsp_accepted,
   output logic                              rsp_invalid,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rov_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rov_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rov_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             push;
   queue_entry_type  push_entry;
   logic             queue_full;
   logic             pop;
   logic             head_valid;
   queue_entry_type  head_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_OVERLAP:    cfg_in.min_overlap    = csr_data[OVL_CFG_W-1:0];
            CSR_MIN_SIMILARITY: cfg_in.min_similarity = csr_data[SIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_overlap    <= OVL_CFG_W'(5);
         cfg_ff.min_similarity <= SIM_W'(922);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rov_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_position  (req_position),
      .req_base      (req_base),
      .req_length_one(req_length_one),
      .req_offset_one(req_offset_one),
      .req_length_two(req_length_two),
      .req_offset_two(req_offset_two),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   rov_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_entry(head_entry)
   );

   rov_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head_valid        (head_valid),
      .head_entry        (head_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_overlap_length(rsp_overlap_length),
      .rsp_mismatch_count(rsp_mismatch_count),
      .rsp_accepted      (rsp_accepted),
      .rsp_invalid       (rsp_invalid)
   );

endmodule

@@ sv/rov_checker.sv @@
// ----------------------------------------------------------------------------
// rov_checker
// Port-level checks of the read overlap verifier, bound to the top level.
// ----------------------------------------------------------------------------
module rov_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [rov_pkg::CNT_W-1:0]    rsp_overlap_length,
   input  logic [rov_pkg::CNT_W-1:0]    rsp_mismatch_count,
   input  logic                         rsp_accepted,
   input  logic                         rsp_invalid
);

   a_reset_clears_rsp : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_overlap_length) &&
      $stable(rsp_mismatch_count) && $stable(rsp_accepted) && $stable(rsp_invalid))
      else $error("stalled response changed");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> !rsp_accepted && rsp_overlap_length == '0 &&
      rsp_mismatch_count == '0)
      else $error("invalid response carries data");

   a_mm_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid |-> rsp_mismatch_count <= rsp_overlap_length &&
      rsp_overlap_length != '0)
      else $error("mismatch count exceeds overlap");

endmodule

bind read_overlap_verifier rov_checker u_rov_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_overlap_length(rsp_overlap_length),
   .rsp_mismatch_count(rsp_mismatch_count),
   .rsp_accepted      (rsp_accepted),
   .rsp_invalid       (rsp_invalid)
);
